>>> hdl/stq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared constants, codes and controller/datapath interface types of the
// sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = 4;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 64;
  localparam logic [TIME_W-1:0] START_TIME = 64'd100;
  localparam logic [15:0]       INC_RESET  = 16'd1;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_MODIFY  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_EXPIRED  = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;
  localparam logic [1:0] ST_NO_TIMER = 2'd3;

  typedef struct packed {
    logic load_in;    // latch request fields
    logic do_simple;  // run reserve/release/modify and push its result
    logic adv_time;   // add tick increment to time reference
    logic scan_clr;   // restart head search
    logic scan_step;  // examine one slot
    logic fire;       // take head as pending result and rearm or free it
    logic push_pend;  // move pending result to output
    logic push_zero;  // push empty tick result
    logic push_last;  // last flag for pushed pending result
  } stq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_tick;
    logic scan_end;
    logic fire_ok;
  } stq_sts_t;

endpackage

>>> hdl/stq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_ctrl
// Sequencer for the timer queue: request intake, head search passes and
// result ordering with last-flag lookahead.
// ----------------------------------------------------------------------------
module stq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  stq_pkg::stq_sts_t sts,
  output stq_pkg::stq_cmd_t cmd
);
  import stq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pend_r, pend_nxt;

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_tick) begin
          cmd.adv_time = 1'b1;
          cmd.scan_clr = 1'b1;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = S_SCAN;
        end else if (sts.out_free) begin
          cmd.do_simple = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_end) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.fire_ok && (cnt_r < CNT_W'(MAX_RESULTS))) begin
          if (!pend_r || sts.out_free) begin
            cmd.push_pend = pend_r;
            cmd.push_last = 1'b0;
            cmd.fire      = 1'b1;
            cmd.scan_clr  = 1'b1;
            cnt_nxt       = cnt_r + 1'b1;
            pend_nxt      = 1'b1;
            state_nxt     = S_SCAN;
          end
        end else if (sts.out_free) begin
          cmd.push_pend = pend_r;
          cmd.push_zero = !pend_r;
          cmd.push_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

>>> hdl/stq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_dp
// Timer slot table, time reference, head search registers, pending result
// and output register of the timer queue.
// ----------------------------------------------------------------------------
module stq_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  stq_pkg::stq_cmd_t cmd,
  output stq_pkg::stq_sts_t sts,
  input  logic             cfg_wr_en,
  input  logic [15:0]      cfg_wr_data,
  input  logic [1:0]       in_operation,
  input  logic [3:0]       in_timer_id,
  input  logic [31:0]      in_delay,
  input  logic             in_periodic,
  input  logic             in_notify_kind,
  input  logic [31:0]      in_target,
  input  logic [31:0]      in_user_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [3:0]       out_timer_id_res,
  output logic             out_notify_kind_res,
  output logic [31:0]      out_target_res,
  output logic [31:0]      out_user_data_res,
  output logic             out_last
);
  import stq_pkg::*;

  // configuration and time reference
  logic [15:0]       inc_r;
  logic [TIME_W-1:0] now_r;

  // latched request
  logic [1:0]  op_r;
  logic [3:0]  id_r;
  logic [31:0] delay_r;
  logic        per_in_r;
  logic        kind_in_r;
  logic [31:0] tgt_in_r;
  logic [31:0] dat_in_r;

  // slot table
  logic [NUM_SLOTS-1:0] used_r;
  logic [TIME_W-1:0]    exp_r   [NUM_SLOTS];
  logic [31:0]          per_r   [NUM_SLOTS];
  logic                 rel_r   [NUM_SLOTS];
  logic                 kind_r  [NUM_SLOTS];
  logic [31:0]          tgt_r   [NUM_SLOTS];
  logic [31:0]          dat_r   [NUM_SLOTS];
  logic [SLOT_W-1:0]    stamp_r [NUM_SLOTS];

  // head search
  logic [SLOT_W-1:0] idx_r;
  logic              found_r;
  logic [SLOT_W-1:0] best_idx_r;
  logic [TIME_W-1:0] best_exp_r;
  logic [SLOT_W-1:0] best_stamp_r;

  // pending expired timer
  logic [SLOT_W-1:0] pend_id_r;
  logic              pend_kind_r;
  logic [31:0]       pend_tgt_r;
  logic [31:0]       pend_dat_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_id_r;
  logic        out_kind_r;
  logic [31:0] out_tgt_r;
  logic [31:0] out_dat_r;
  logic        out_last_r;

  // combinational helpers
  logic              out_free;
  logic [SLOT_W-1:0] rd_idx;
  logic [SLOT_W-1:0] free_idx;
  logic              free_found;
  logic              id_used;
  logic [1:0]        simple_status;
  logic [3:0]        simple_id;
  logic [SLOT_W-1:0] act_slot;
  logic              arm_en;
  logic              arm_per_en;
  logic [31:0]       arm_per;
  logic [31:0]       arm_delay;
  logic              arm_rel;
  logic              ins_en;
  logic              bump_all;
  logic              bump_newer;
  logic              drop_en;
  logic [31:0]       fire_per;
  logic              cand_better;

  assign out_free = !out_valid_r || !out_stall;

  // single table read address
  always_comb begin
    if (cmd.scan_step)  rd_idx = idx_r;
    else if (cmd.fire)  rd_idx = best_idx_r;
    else                rd_idx = id_r;
  end

  // lowest free slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (!used_r[j]) begin
        free_idx   = SLOT_W'(j);
        free_found = 1'b1;
      end
    end
  end

  assign id_used = used_r[id_r];

  // result of a reserve, release or modify
  always_comb begin
    if (op_r == OP_RESERVE) begin
      simple_status = free_found ? ST_DONE : ST_NO_SLOT;
      simple_id     = free_found ? free_idx : '0;
    end else begin
      simple_status = id_used ? ST_DONE : ST_NO_TIMER;
      simple_id     = id_r;
    end
  end

  assign fire_per = (per_r[rd_idx] == 32'd0) ? 32'd1 : per_r[rd_idx];

  // table update controls
  always_comb begin
    act_slot   = id_r;
    arm_en     = 1'b0;
    arm_per_en = 1'b0;
    arm_per    = delay_r;
    arm_delay  = delay_r;
    arm_rel    = per_in_r;
    ins_en     = 1'b0;
    bump_all   = 1'b0;
    bump_newer = 1'b0;
    drop_en    = 1'b0;
    if (cmd.do_simple) begin
      case (op_r)
        OP_RESERVE: begin
          act_slot   = free_idx;
          arm_en     = free_found;
          arm_per_en = free_found;
          arm_per    = per_in_r ? delay_r : 32'd0;
          ins_en     = free_found;
          bump_all   = free_found;
        end
        OP_RELEASE: begin
          drop_en = id_used;
        end
        OP_MODIFY: begin
          arm_en     = id_used;
          arm_per_en = id_used && per_in_r;
          bump_newer = id_used;
        end
        default: ;
      endcase
    end else if (cmd.fire) begin
      act_slot = best_idx_r;
      if (rel_r[rd_idx]) begin
        arm_en     = 1'b1;
        arm_per_en = 1'b1;
        arm_per    = fire_per;
        arm_delay  = fire_per;
        arm_rel    = 1'b1;
        bump_newer = 1'b1;
      end else begin
        drop_en = 1'b1;
      end
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (SLOT_W'(j) == act_slot) begin
          if (arm_en) begin
            exp_r[j]   <= now_r + {32'd0, arm_delay};
            rel_r[j]   <= arm_rel;
            stamp_r[j] <= '0;
          end
          if (arm_per_en) per_r[j] <= arm_per;
          if (ins_en) begin
            used_r[j] <= 1'b1;
            kind_r[j] <= kind_in_r;
            tgt_r[j]  <= tgt_in_r;
            dat_r[j]  <= dat_in_r;
          end
          if (drop_en) used_r[j] <= 1'b0;
        end else if (used_r[j]) begin
          if (bump_all || (bump_newer && stamp_r[j] < stamp_r[rd_idx]))
            stamp_r[j] <= stamp_r[j] + 1'b1;
          else if (drop_en && stamp_r[j] > stamp_r[rd_idx])
            stamp_r[j] <= stamp_r[j] - 1'b1;
        end
      end
    end
  end

  // configuration and time reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= INC_RESET;
      now_r <= START_TIME;
    end else begin
      if (cfg_wr_en)    inc_r <= cfg_wr_data;
      if (cmd.adv_time) now_r <= now_r + {48'd0, inc_r};
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r      <= in_operation;
      id_r      <= in_timer_id;
      delay_r   <= in_delay;
      per_in_r  <= in_periodic;
      kind_in_r <= in_notify_kind;
      tgt_in_r  <= in_target;
      dat_in_r  <= in_user_data;
    end
  end

  // head search, one slot per cycle
  assign cand_better = !found_r || (exp_r[rd_idx] < best_exp_r) ||
                       ((exp_r[rd_idx] == best_exp_r) && (stamp_r[rd_idx] < best_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_clr) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (used_r[rd_idx] && cand_better) begin
        found_r      <= 1'b1;
        best_idx_r   <= rd_idx;
        best_exp_r   <= exp_r[rd_idx];
        best_stamp_r <= stamp_r[rd_idx];
      end
    end
  end

  // pending expired timer
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      pend_id_r   <= best_idx_r;
      pend_kind_r <= kind_r[rd_idx];
      pend_tgt_r  <= tgt_r[rd_idx];
      pend_dat_r  <= dat_r[rd_idx];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_simple || cmd.push_pend || cmd.push_zero) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_simple) begin
      out_status_r <= simple_status;
      out_id_r     <= simple_id;
      out_kind_r   <= 1'b0;
      out_tgt_r    <= '0;
      out_dat_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.push_pend) begin
      out_status_r <= ST_EXPIRED;
      out_id_r     <= pend_id_r;
      out_kind_r   <= pend_kind_r;
      out_tgt_r    <= pend_tgt_r;
      out_dat_r    <= pend_dat_r;
      out_last_r   <= cmd.push_last;
    end else if (cmd.push_zero) begin
      out_status_r <= ST_DONE;
      out_id_r     <= '0;
      out_kind_r   <= 1'b0;
      out_tgt_r    <= '0;
      out_dat_r    <= '0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_timer_id_res    = out_id_r;
  assign out_notify_kind_res = out_kind_r;
  assign out_target_res      = out_tgt_r;
  assign out_user_data_res   = out_dat_r;
  assign out_last            = out_last_r;

  // status to controller
  assign sts.out_free = out_free;
  assign sts.is_tick  = (op_r == OP_TICK);
  assign sts.scan_end = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign sts.fire_ok  = found_r && (best_exp_r <= now_r);

endmodule

>>> hdl/sorted_timer_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer slot table kept in expiry order against a running time reference;
// reserve, release, modify and tick requests, expired timers out in order.
// ----------------------------------------------------------------------------
//   channel | signals                          | direction
//   in      | in_valid / in_stall + fields     | request in
//   out     | out_valid / out_stall + fields   | results out, last marks end
//   cfg     | cfg_wr_en / cfg_wr_data          | tick increment write
//
// reserve, release and modify are latched, then run once the output register is free.
// a tick advances the time, then runs one head search (one slot per cycle over 16
// slots) per expired timer plus a final one, for up to 16 expired timers.
// reset is synchronous; time restarts at 100, all slots free, increment 1.
// output stalls hold the sequencer at the next result push.
module sorted_timer_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_delay,
  input  logic        in_periodic,
  input  logic        in_notify_kind,
  input  logic [31:0] in_target,
  input  logic [31:0] in_user_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [3:0]  out_timer_id_res,
  output logic        out_notify_kind_res,
  output logic [31:0] out_target_res,
  output logic [31:0] out_user_data_res,
  output logic        out_last
);
  import stq_pkg::*;

  stq_cmd_t cmd;
  stq_sts_t sts;

  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stq_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_operation        (in_operation),
    .in_timer_id         (in_timer_id),
    .in_delay            (in_delay),
    .in_periodic         (in_periodic),
    .in_notify_kind      (in_notify_kind),
    .in_target           (in_target),
    .in_user_data        (in_user_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_timer_id_res    (out_timer_id_res),
    .out_notify_kind_res (out_notify_kind_res),
    .out_target_res      (out_target_res),
    .out_user_data_res   (out_user_data_res),
    .out_last            (out_last)
  );

endmodule

>>> dv/stq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker
// Watches the request, result and register channels of the sorted timer
// queue, keeps its own timer table and time reference, predicts the results
// of each accepted request and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module stq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [3:0]  in_timer_id,
  input  logic [31:0] in_delay,
  input  logic        in_periodic,
  input  logic        in_notify_kind,
  input  logic [31:0] in_target,
  input  logic [31:0] in_user_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_timer_id_res,
  input  logic        out_notify_kind_res,
  input  logic [31:0] out_target_res,
  input  logic [31:0] out_user_data_res,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  import stq_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  id;
    logic        kind;
    logic [31:0] tgt;
    logic [31:0] dat;
    logic        last;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [15:0]       tick_inc;
  logic [TIME_W-1:0] now_t;
  logic              used  [NUM_SLOTS];
  logic [TIME_W-1:0] expiry[NUM_SLOTS];
  logic [31:0]       period[NUM_SLOTS];
  logic              reload[NUM_SLOTS];
  logic              kind_m[NUM_SLOTS];
  logic [31:0]       tgt_m [NUM_SLOTS];
  logic [31:0]       dat_m [NUM_SLOTS];
  int                rank  [NUM_SLOTS];

  assign pending_count = expected_results.size();

  function automatic timer_result_t mk(logic [1:0] st, logic [3:0] id, logic k,
                                       logic [31:0] t, logic [31:0] d, logic l);
    timer_result_t r;
    r.status = st; r.id = id; r.kind = k; r.tgt = t; r.dat = d; r.last = l;
    return r;
  endfunction

  // move slot to most recent; old rank 255 means just inserted
  task automatic promote(int s, int old_rank);
    for (int j = 0; j < NUM_SLOTS; j++)
      if (j != s && used[j] && rank[j] < old_rank) rank[j]++;
    rank[s] = 0;
  endtask

  task automatic drop(int s);
    for (int j = 0; j < NUM_SLOTS; j++)
      if (j != s && used[j] && rank[j] > rank[s]) rank[j]--;
    used[s] = 1'b0;
  endtask

  task automatic arm(int s, logic [31:0] d, logic per);
    reload[s] = per;
    if (per) period[s] = d;
    expiry[s] = now_t + {32'd0, d};
    promote(s, rank[s]);
  endtask

  // expected results of one request, state updated
  task automatic predict_request(logic [1:0] op, logic [3:0] id, logic [31:0] d,
                                 logic per, logic k, logic [31:0] t,
                                 logic [31:0] dt);
    int n, s, best;
    n = 0;
    if (op == OP_TICK) begin
      now_t = now_t + {48'd0, tick_inc};
      while (n < MAX_RESULTS) begin
        best = -1;
        for (int j = 0; j < NUM_SLOTS; j++)
          if (used[j] && (best < 0 || expiry[j] < expiry[best] ||
              (expiry[j] == expiry[best] && rank[j] < rank[best]))) best = j;
        if (best < 0 || now_t < expiry[best]) break;
        expected_results.push_back(mk(ST_EXPIRED, best[3:0], kind_m[best],
                                      tgt_m[best], dat_m[best], 1'b0));
        n++;
        if (reload[best]) arm(best, period[best] == 0 ? 32'd1 : period[best], 1'b1);
        else drop(best);
      end
      if (n == 0) expected_results.push_back(mk(ST_DONE, 0, 0, 0, 0, 1'b1));
      else expected_results[$].last = 1'b1;
    end else if (op == OP_RESERVE) begin
      s = -1;
      for (int j = NUM_SLOTS - 1; j >= 0; j--) if (!used[j]) s = j;
      if (s < 0) begin
        expected_results.push_back(mk(ST_NO_SLOT, 0, 0, 0, 0, 1'b1));
      end else begin
        kind_m[s] = k; tgt_m[s] = t; dat_m[s] = dt; period[s] = 0;
        used[s] = 1'b1; rank[s] = 255;
        arm(s, d, per);
        expected_results.push_back(mk(ST_DONE, s[3:0], 0, 0, 0, 1'b1));
      end
    end else if (!used[id]) begin
      expected_results.push_back(mk(ST_NO_TIMER, id, 0, 0, 0, 1'b1));
    end else begin
      if (op == OP_RELEASE) drop(id);
      else arm(id, d, per);
      expected_results.push_back(mk(ST_DONE, id, 0, 0, 0, 1'b1));
    end
  endtask

  // watch all three channels
  always @(posedge clk) begin
    timer_result_t got, exp_r;
    if (!rst_n) begin
      tick_inc = INC_RESET;
      now_t = START_TIME;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        used[j] = 0; rank[j] = 0;
      end
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) tick_inc = cfg_wr_data;
      if (out_valid && !out_stall) begin
        got = mk(out_status, out_timer_id_res, out_notify_kind_res,
                 out_target_res, out_user_data_res, out_last);
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected %h actual %h", exp_r, got);
          end
        end
      end
      if (in_valid && !in_stall)
        predict_request(in_operation, in_timer_id, in_delay, in_periodic,
                        in_notify_kind, in_target, in_user_data);
    end
  end

endmodule

>>> dv/sorted_timer_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_tb
// Drives directed and random reserve, release, modify and tick requests under
// several tick increments with random stalls; the checker scores results.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
  import stq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk, rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid, in_stall;
  logic [1:0]  in_operation;
  logic [3:0]  in_timer_id;
  logic [31:0] in_delay, in_target, in_user_data;
  logic        in_periodic, in_notify_kind;
  logic        out_valid, out_stall;
  logic [1:0]  out_status;
  logic [3:0]  out_timer_id_res;
  logic        out_notify_kind_res, out_last;
  logic [31:0] out_target_res, out_user_data_res;
  int          fail_count, pending_count;
  int          idle_cycles;
  logic        calm;

  sorted_timer_queue uut (.*);
  stq_checker chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog on accepted requests and results
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result-side stall bursts
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // valid stays up after acceptance until the next request or an idle period
  task automatic send_request(logic [1:0] op, logic [3:0] id, logic [31:0] d,
                              logic per, logic k, logic [31:0] t, logic [31:0] dt);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1; in_operation <= op; in_timer_id <= id; in_delay <= d;
    in_periodic <= per; in_notify_kind <= k; in_target <= t; in_user_data <= dt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_increment(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_request();
    logic [31:0] d;
    logic [1:0] op;
    case ($urandom_range(0, 3))
      0: d = $urandom;
      1: d = 32'hFFFF_FFFF;
      default: d = $urandom_range(0, 40);
    endcase
    op = ($urandom_range(0, 2) == 0) ? OP_TICK : 2'($urandom_range(0, 3));
    send_request(op, 4'($urandom), d, 1'($urandom), 1'($urandom), $urandom, $urandom);
  endtask

  initial begin
    logic [15:0] incs[5];
    incs = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd7};
    calm = 1'b0;
    rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0;
    in_operation = OP_TICK; in_timer_id = '0; in_delay = '0; in_periodic = 1'b0;
    in_notify_kind = 1'b0; in_target = '0; in_user_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: free-slot errors, fill table, equal expiry, full table, ticks
    send_request(OP_RELEASE, 4'd15, 0, 0, 0, 0, 0);
    send_request(OP_MODIFY, 4'd0, 5, 1, 0, 0, 0);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 16; i++)
      send_request(OP_RESERVE, 0, (i < 14) ? 32'd2 : 32'hFFFF_FFFF, i[0], ~i[1],
                   32'hFFFF_FFFF - i, i);
    send_request(OP_RESERVE, 0, 0, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_MODIFY, 4'd3, 0, 1, 0, 0, 0);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0);
    send_request(OP_RELEASE, 4'd15, 0, 0, 0, 0, 0);

    for (int p = 0; p < 5; p++) begin
      set_increment(incs[p]);
      if (p == 4) calm = 1'b1;
      for (int i = 0; i < 85; i++) random_request();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
